FILE: design/pu2x_pkg.sv
// Shared types, constants and helpers of the 2x midpoint upscaler.
`default_nettype none
package pu2x_pkg;

  localparam int DefMaxWidth = 1024;
  localparam int DefScaleFactor = 2;
  localparam int HeightCap = 1024;
  localparam int CfgW = 11;
  localparam int CfgIdxW = 2;
  localparam int CoordW = 11;
  localparam int RowW = 10;
  localparam int ChanW = 8;

  localparam logic [CfgIdxW-1:0] REG_SRC_WIDTH = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SRC_HEIGHT = 2'd1;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pixel_t;

  function automatic pixel_t pix_mid(input pixel_t a, input pixel_t b);
    logic [ChanW:0] sr;
    logic [ChanW:0] sg;
    logic [ChanW:0] sb;
    pixel_t res;
    sr = {1'b0, a.red} + {1'b0, b.red};
    sg = {1'b0, a.green} + {1'b0, b.green};
    sb = {1'b0, a.blue} + {1'b0, b.blue};
    res.red = sr[ChanW:1];
    res.green = sg[ChanW:1];
    res.blue = sb[ChanW:1];
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: design/pu2x_line_mem.sv
// Line memory holding the previous source row, one pixel per column.
`default_nettype none
module pu2x_line_mem #(
  parameter int Depth = 1024,
  parameter int AddrW = 10
) (
  input  wire logic            clk,
  input  wire logic            access,
  input  wire logic [AddrW-1:0] addr,
  input  wire pu2x_pkg::pixel_t wdata,
  output pu2x_pkg::pixel_t      rdata
);
  import pu2x_pkg::*;

  pixel_t mem [Depth];

  always_ff @(posedge clk) begin
    if (access) begin
      rdata <= mem[addr];
      mem[addr] <= wdata;
    end
  end

endmodule
`default_nettype wire

FILE: design/pixel_upscale_2x_midpoint.sv
// Top level of the streaming 2x midpoint upscaler for BGR pixels.
//
// Source pixels enter in raster order on the input channel (in_valid, in_stall);
// each word is one pixel. Every upscaled pixel that an input completes leaves
// on the output channel (out_valid, out_stall) in row-major order, tagged with
// its output row and column; run_last marks the final word caused by an input.
// An input yields one to nine output words, four on average.
// An accepted item passes stage 1 and stage 2; its output words are registered.
// Output runs at one word per cycle while out_stall is low; an item holds the
// emit stage until its last result leaves; the emit sequencer sets throughput.
// The previous row lives in a single-port line memory that is read and written
// in the acceptance cycle of each pixel.
// Write src_width/src_height via cfg_write/cfg_index/cfg_data only while the
// block is idle (not enforced); a write to either restarts the frame.
// Reset (rst, synchronous) sets both sizes to 1 and clears the row and column
// counters, valid flags and neighbor registers; the line memory is not cleared.
// When the receiver stalls, the output word holds and the two internal stages
// fill before in_stall rises.
`default_nettype none
module pixel_upscale_2x_midpoint #(
  parameter int MaxWidth = pu2x_pkg::DefMaxWidth,
  parameter int ScaleFactor = pu2x_pkg::DefScaleFactor
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [pu2x_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [pu2x_pkg::CfgW-1:0]      cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [pu2x_pkg::ChanW-1:0]     in_blue,
  input  wire logic [pu2x_pkg::ChanW-1:0]     in_green,
  input  wire logic [pu2x_pkg::ChanW-1:0]     in_red,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [pu2x_pkg::CoordW-1:0]         out_row,
  output logic [pu2x_pkg::CoordW-1:0]         out_col,
  output logic [pu2x_pkg::ChanW-1:0]          out_blue,
  output logic [pu2x_pkg::ChanW-1:0]          out_green,
  output logic [pu2x_pkg::ChanW-1:0]          out_red,
  output logic                                run_last
);
  import pu2x_pkg::*;

  localparam int WidthCap = (MaxWidth < 1024) ? MaxWidth : 1024;
  localparam int AddrW = (WidthCap > 1) ? $clog2(WidthCap) : 1;
  localparam logic [CfgW-1:0] WidthCapV = CfgW'(WidthCap);
  localparam logic [CfgW-1:0] HeightCapV = CfgW'(HeightCap);
  localparam logic [CoordW-1:0] Scale = CoordW'(ScaleFactor);

  logic [CfgW-1:0] src_width;
  logic [CfgW-1:0] src_height;
  logic [CfgW-1:0] eff_w;
  logic [CfgW-1:0] eff_h;

  logic [AddrW-1:0] col_count;
  logic [RowW-1:0] row_count;
  logic col_is_last;
  logic row_is_last;

  logic accept;
  logic transfer;
  logic advance;
  logic out_ready;

  pixel_t in_pix;
  pixel_t line_rd;

  // Stage 1: pixel waiting for its line memory read.
  logic s1_valid;
  pixel_t s1_cur;
  logic [AddrW-1:0] s1_col;
  logic [RowW-1:0] s1_row;
  logic s1_last_col;
  logic s1_last_row;

  // Neighbor registers.
  pixel_t left_pixel;
  pixel_t up_left_pixel;

  // Stage 2: pixel whose results are being emitted.
  logic s2_valid;
  pixel_t s2_cur;
  pixel_t s2_up;
  pixel_t s2_ul;
  pixel_t s2_lf;
  logic [AddrW-1:0] s2_col;
  logic [RowW-1:0] s2_row;
  logic s2_last_col;
  logic s2_last_row;
  logic [1:0] ci;
  logic [1:0] ri;
  logic [1:0] ci_start;

  logic col_end;
  logic row_end;
  logic done;
  pixel_t low_pix;
  pixel_t high_pix;
  pixel_t emit_pix;
  logic [CoordW-1:0] emit_row;
  logic [CoordW-1:0] emit_col;

  assign in_pix = '{red: in_red, green: in_green, blue: in_blue};

  always_comb begin
    if (src_width == '0) begin
      eff_w = CfgW'(1);
    end else if (src_width > WidthCapV) begin
      eff_w = WidthCapV;
    end else begin
      eff_w = src_width;
    end
    if (src_height == '0) begin
      eff_h = CfgW'(1);
    end else if (src_height > HeightCapV) begin
      eff_h = HeightCapV;
    end else begin
      eff_h = src_height;
    end
  end

  assign col_is_last = (CfgW'(col_count) + CfgW'(1)) >= eff_w;
  assign row_is_last = (CfgW'(row_count) + CfgW'(1)) >= eff_h;

  assign col_end = (ci == 2'd2) || ((ci == 2'd1) && !s2_last_col);
  assign row_end = (ri == 2'd2) || ((ri == 2'd1) && !s2_last_row);
  assign done = col_end && row_end;

  assign out_ready = !out_valid || !out_stall;
  assign advance = s2_valid && out_ready;
  assign transfer = s1_valid && (!s2_valid || (advance && done));
  assign in_stall = s1_valid && !transfer;
  assign accept = in_valid && !in_stall;

  pu2x_line_mem #(
    .Depth(WidthCap),
    .AddrW(AddrW)
  ) u_line_mem (
    .clk(clk),
    .access(accept),
    .addr(col_count),
    .wdata(in_pix),
    .rdata(line_rd)
  );

  always_comb begin
    if (ci == 2'd0) begin
      low_pix = pix_mid(s2_lf, s2_cur);
      high_pix = pix_mid(s2_ul, s2_up);
    end else begin
      low_pix = s2_cur;
      high_pix = s2_up;
    end
    if (ri == 2'd0) begin
      emit_pix = pix_mid(high_pix, low_pix);
    end else begin
      emit_pix = low_pix;
    end
    emit_row = Scale * CoordW'(s2_row) + CoordW'(ri) - CoordW'(1);
    emit_col = Scale * CoordW'(s2_col) + CoordW'(ci) - CoordW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width <= CfgW'(1);
      src_height <= CfgW'(1);
      col_count <= '0;
      row_count <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      out_valid <= 1'b0;
      left_pixel <= '0;
      up_left_pixel <= '0;
      ci <= 2'd1;
      ri <= 2'd1;
      ci_start <= 2'd1;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_SRC_WIDTH) begin
          src_width <= cfg_data;
          col_count <= '0;
          row_count <= '0;
        end else if (cfg_index == REG_SRC_HEIGHT) begin
          src_height <= cfg_data;
          col_count <= '0;
          row_count <= '0;
        end
      end else if (accept) begin
        if (col_is_last) begin
          col_count <= '0;
          row_count <= row_is_last ? '0 : row_count + RowW'(1);
        end else begin
          col_count <= col_count + AddrW'(1);
        end
      end

      if (accept) begin
        s1_valid <= 1'b1;
        s1_cur <= in_pix;
        s1_col <= col_count;
        s1_row <= row_count;
        s1_last_col <= col_is_last;
        s1_last_row <= row_is_last;
      end else if (transfer) begin
        s1_valid <= 1'b0;
      end

      if (transfer) begin
        s2_valid <= 1'b1;
        s2_cur <= s1_cur;
        s2_up <= line_rd;
        s2_ul <= up_left_pixel;
        s2_lf <= left_pixel;
        s2_col <= s1_col;
        s2_row <= s1_row;
        s2_last_col <= s1_last_col;
        s2_last_row <= s1_last_row;
        ci <= (s1_col != '0) ? 2'd0 : 2'd1;
        ci_start <= (s1_col != '0) ? 2'd0 : 2'd1;
        ri <= (s1_row != '0) ? 2'd0 : 2'd1;
        up_left_pixel <= line_rd;
        left_pixel <= s1_cur;
      end else if (advance) begin
        if (done) begin
          s2_valid <= 1'b0;
        end else if (col_end) begin
          ci <= ci_start;
          ri <= ri + 2'd1;
        end else begin
          ci <= ci + 2'd1;
        end
      end

      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_row <= emit_row;
      out_col <= emit_col;
      out_blue <= emit_pix.blue;
      out_green <= emit_pix.green;
      out_red <= emit_pix.red;
      run_last <= done;
    end
  end

endmodule
`default_nettype wire
